// File: rtl/ncht_pkg.sv
// Shared types and constants for the node count hash table.
package ncht_pkg;

    // Action codes
    localparam logic ACT_LOOKUP = 1'b0;
    localparam logic ACT_STORE  = 1'b1;

    // Field positions inside a deep info word
    localparam int DEPTH_SHIFT = 58;
    localparam int DEPTH_BITS  = 6;

    // Input word
    typedef struct packed {
        logic        action;
        logic [63:0] hash_key;
        logic [5:0]  depth;
        logic [55:0] node_count;
    } t_in_word;

    // Result word
    typedef struct packed {
        logic        found;
        logic [55:0] count_out;
    } t_out_word;

    // One bucket as held in memory
    typedef struct packed {
        logic [1:0][63:0] di;
        logic [1:0][63:0] dk;
        logic [3:0][63:0] sh;
    } t_bucket;

    // Short slot: count in 63..32, key bits 63..36 in 31..4, depth in 3..0
    function automatic logic [63:0] short_make(input logic [63:0] key,
                                               input logic [5:0]  d,
                                               input logic [31:0] n);
        return {n, key[63:36], d[3:0]};
    endfunction

endpackage

// File: rtl/ncht_ram.sv
// Generic single-port-write, registered-read RAM.
module ncht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/node_count_hash_table_core.sv
// Node count hash table: bucketed store and lookup of node counts.
//
// Input channel (i_in_valid / o_in_ready / i_in_data) takes one word: a
// lookup or a store of a 64-bit key, a depth and a count. Output channel
// (o_out_valid / i_out_ready / o_out_data) returns one word per input:
// found flag and count (both zero on a miss and on every store).
// The bucket is the low bits of the key; BUCKET_COUNT must be a power of two.
// Each word is handled in steps: its bucket is read from the single bucket
// memory (registered read); then the bucket is updated, written back and the
// result register loaded. A new word is accepted only after that write-back.
// The generation register is written via i_cfg_we / i_cfg_data; the user must
// write it only while idle, as the block itself does not enforce this. After
// reset the block clears the memory one bucket a cycle, with o_in_ready low;
// the generation resets to 0. When the receiver stalls, the result waits in
// the output register; the next word may be accepted, but its write-back
// waits until the result register is free.
module node_count_hash_table_core #(
    parameter int BUCKET_COUNT = 1024,
    parameter int AGE_BITS     = 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  ncht_pkg::t_in_word  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ncht_pkg::t_out_word o_out_data,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_data
);

    localparam int AW = $clog2(BUCKET_COUNT);
    localparam int CB = ncht_pkg::DEPTH_SHIFT - AGE_BITS;   // deep count bits
    localparam int BW = $bits(ncht_pkg::t_bucket);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_RD    = 2'd2;

    logic [1:0]          r_state, n_state;
    logic [AW-1:0]       r_clr;
    logic [1:0]          r_gen;
    ncht_pkg::t_in_word  r_item;
    logic                r_out_valid;
    ncht_pkg::t_out_word r_out, n_out;

    logic                accept, out_free, upd;
    logic [AW-1:0]       raddr, waddr;
    logic                we;
    logic [BW-1:0]       rdata, wdata;
    ncht_pkg::t_bucket   bk, nb;

    assign accept   = (r_state == ST_IDLE) && i_in_valid;
    assign out_free = !r_out_valid || i_out_ready;
    assign upd      = (r_state == ST_RD) && out_free;

    // Bucket memory
    assign raddr = accept ? i_in_data.hash_key[AW-1:0] : r_item.hash_key[AW-1:0];
    assign we    = (r_state == ST_CLEAR) || upd;
    assign waddr = (r_state == ST_CLEAR) ? r_clr : r_item.hash_key[AW-1:0];
    assign wdata = (r_state == ST_CLEAR) ? '0 : BW'(nb);
    assign bk    = ncht_pkg::t_bucket'(rdata);

    ncht_ram #(
        .WIDTH (BW),
        .DEPTH (BUCKET_COUNT)
    ) u_bucket_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Bucket update and result
    always_comb begin
        logic [63:0]        key;
        logic [5:0]         d;
        logic [55:0]        n;
        logic [AGE_BITS-1:0] gen;
        logic [31:0]        tag;
        logic               hit;
        logic [5:0]         b0d, b1d;
        logic [CB-1:0]      c0, c1;
        logic [63:0]        i0;
        logic [63:0]        new_info;
        key = r_item.hash_key;
        d   = r_item.depth;
        n   = r_item.node_count;
        gen = AGE_BITS'(r_gen);
        tag = {key[63:36], d[3:0]};
        hit = 1'b0;
        b0d = bk.di[0][ncht_pkg::DEPTH_SHIFT +: ncht_pkg::DEPTH_BITS];
        b1d = bk.di[1][ncht_pkg::DEPTH_SHIFT +: ncht_pkg::DEPTH_BITS];
        c0  = bk.di[0][CB-1:0];
        c1  = bk.di[1][CB-1:0];
        i0  = bk.di[0];
        new_info = {d, gen, CB'(n)};
        nb    = bk;
        n_out = '0;
        if (r_item.action == ncht_pkg::ACT_LOOKUP) begin
            // Short slots first, in order
            for (int i = 0; i < 4; i++) begin
                if (!hit && bk.sh[i][31:0] == tag) begin
                    hit = 1'b1;
                    n_out.found     = 1'b1;
                    n_out.count_out = 56'(bk.sh[i][63:32]);
                end
            end
            if (!hit && bk.dk[0] == key && b0d == d) begin
                n_out.found     = 1'b1;
                n_out.count_out = 56'(c0);
                // refresh age and promote
                if (d >= b1d) begin
                    i0[CB +: AGE_BITS] = gen;
                    nb.dk[0] = bk.dk[1];
                    nb.di[0] = bk.di[1];
                    nb.dk[1] = bk.dk[0];
                    nb.di[1] = i0;
                end
            end else if (!hit && bk.dk[1] == key && b1d == d) begin
                n_out.found     = 1'b1;
                n_out.count_out = 56'(c1);
            end
        end else begin
            if (bk.di[0][CB +: AGE_BITS] == gen && d < b0d
                    && n[55:32] == '0 && d[5:4] == '0) begin
                // shallow entry into the short slots
                if (d == 6'd0) begin
                    nb.sh[0] = ncht_pkg::short_make(key, d, n[31:0]);
                end else if (d == 6'd1) begin
                    nb.sh[0] = bk.sh[1];
                    nb.sh[1] = ncht_pkg::short_make(key, d, n[31:0]);
                end else begin
                    nb.sh[0] = bk.sh[1];
                    nb.sh[1] = bk.sh[2];
                    if (d[3:0] >= bk.sh[3][3:0]) begin
                        nb.sh[2] = bk.sh[3];
                        nb.sh[3] = ncht_pkg::short_make(key, d, n[31:0]);
                    end else begin
                        nb.sh[2] = ncht_pkg::short_make(key, d, n[31:0]);
                    end
                end
            end else begin
                // demote a shallow deep entry
                if (b0d <= 6'd4 && c0[CB-1:32] == '0) begin
                    nb.sh[0] = bk.sh[1];
                    nb.sh[1] = bk.sh[2];
                    nb.sh[2] = bk.sh[3];
                    nb.sh[3] = ncht_pkg::short_make(bk.dk[0], b0d, c0[31:0]);
                end
                if (bk.di[1][CB +: AGE_BITS] == gen && d < b1d) begin
                    nb.dk[0] = key;
                    nb.di[0] = new_info;
                end else begin
                    nb.dk[0] = bk.dk[1];
                    nb.di[0] = bk.di[1];
                    nb.dk[1] = key;
                    nb.di[1] = new_info;
                end
            end
        end
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (r_clr == AW'(BUCKET_COUNT - 1)) n_state = ST_IDLE;
            ST_IDLE:  if (accept) n_state = ST_RD;
            ST_RD:    if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_gen       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cfg_we) begin
                r_gen <= i_cfg_data;
            end
            if (upd) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_in_data;
        end
        if (upd) begin
            r_out <= n_out;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
